/* rtl/yuyv_to_rgb888_pair_defines.svh */
// Assertion macros for the YUYV to RGB888 pair converter.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef YUYV_TO_RGB888_PAIR_DEFINES_SVH
`define YUYV_TO_RGB888_PAIR_DEFINES_SVH

// same-cycle implication
`define YRGB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define YRGB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/yrgb_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and saturation function for the YUYV to RGB888 converter.
// No dependencies.
package yrgb_pkg;

	localparam int FRAC_BITS = 12;
	localparam int PIX_W     = 8;
	localparam int CHR_W     = 8;
	localparam int ACC_W     = 23;
	localparam int IN_W      = 4 * PIX_W;
	localparam int OUT_W     = 6 * PIX_W;

	localparam logic signed [ACC_W-1:0] COEF_R_U = ACC_W'(5743);
	localparam logic signed [ACC_W-1:0] COEF_G_U = ACC_W'(1409);
	localparam logic signed [ACC_W-1:0] COEF_G_V = ACC_W'(2925);
	localparam logic signed [ACC_W-1:0] COEF_B_V = ACC_W'(7258);

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic signed [CHR_W-1:0] chroma_t;
	typedef logic signed [ACC_W-1:0] acc_t;

	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
	} yrgb_ctrl_t;

	// floor(acc / 4096), saturated to 0..255
	function automatic pix_t sat_chan(input acc_t acc);
		pix_t res;
		if (acc[ACC_W-1]) begin
			res = '0;
		end else if (|acc[ACC_W-2:FRAC_BITS+PIX_W]) begin
			res = '1;
		end else begin
			res = acc[FRAC_BITS+PIX_W-1:FRAC_BITS];
		end
		return res;
	endfunction

endpackage

/* rtl/yrgb_datapath.sv */
`timescale 1ns / 1ps
// Four-stage arithmetic pipeline: chroma centring, products, sums, shift and saturate.
// Depends on yrgb_pkg; stage loads come from the top level's handshake control.
module yrgb_datapath (
	input  logic                        clk,
	input  yrgb_pkg::yrgb_ctrl_t        ctrl,
	input  logic [yrgb_pkg::IN_W-1:0]   in_word,  // luma_first, chroma_u, luma_second, chroma_v
	output logic [yrgb_pkg::OUT_W-1:0]  out_word  // b0, g0, r0, b1, g1, r1
);
	import yrgb_pkg::*;

	pix_t    y0_s1, y1_s1, y0_s2, y1_s2;
	chroma_t du_s1, dv_s1;
	acc_t    ru_s2, gu_s2, gv_s2, bv_s2;
	acc_t    b0_s3, g0_s3, r0_s3, b1_s3, g1_s3, r1_s3;
	acc_t    base0, base1;

	assign base0 = acc_t'({1'b0, y0_s2, {FRAC_BITS{1'b0}}});
	assign base1 = acc_t'({1'b0, y1_s2, {FRAC_BITS{1'b0}}});

	// s1: centre chroma on 128
	always_ff @(posedge clk) begin
		if (ctrl.en_s1) begin
			y0_s1 <= in_word[PIX_W-1:0];
			du_s1 <= {~in_word[2*PIX_W-1], in_word[2*PIX_W-2:PIX_W]};
			y1_s1 <= in_word[3*PIX_W-1:2*PIX_W];
			dv_s1 <= {~in_word[4*PIX_W-1], in_word[4*PIX_W-2:3*PIX_W]};
		end
	end

	// s2: chroma products, shared by both pixels
	always_ff @(posedge clk) begin
		if (ctrl.en_s2) begin
			y0_s2 <= y0_s1;
			y1_s2 <= y1_s1;
			ru_s2 <= COEF_R_U * acc_t'(du_s1);
			gu_s2 <= COEF_G_U * acc_t'(du_s1);
			gv_s2 <= COEF_G_V * acc_t'(dv_s1);
			bv_s2 <= COEF_B_V * acc_t'(dv_s1);
		end
	end

	// s3: add luma
	always_ff @(posedge clk) begin
		if (ctrl.en_s3) begin
			b0_s3 <= base0 + bv_s2;
			g0_s3 <= base0 - gu_s2 - gv_s2;
			r0_s3 <= base0 + ru_s2;
			b1_s3 <= base1 + bv_s2;
			g1_s3 <= base1 - gu_s2 - gv_s2;
			r1_s3 <= base1 + ru_s2;
		end
	end

	// s4: shift and saturate into the output register
	always_ff @(posedge clk) begin
		if (ctrl.en_s4) begin
			out_word <= {sat_chan(r1_s3), sat_chan(g1_s3), sat_chan(b1_s3),
				sat_chan(r0_s3), sat_chan(g0_s3), sat_chan(b0_s3)};
		end
	end

endmodule

/* rtl/yuyv_to_rgb888_pair.sv */
`timescale 1ns / 1ps
// YUYV 4:2:2 macro-pixel to two RGB888 pixels, BT.601 full range, red and blue chroma roles swapped.
// An accepted input word passes through the stage 1 to stage 4 registers to become the output word.
// Throughput: one word per cycle; each stage holds while the one after it is full and stalled.
// Reset clears the stage valid bits only; datapath registers are not reset.
// Depends on yrgb_pkg, yrgb_datapath and yuyv_to_rgb888_pair_defines.svh.
`include "yuyv_to_rgb888_pair_defines.svh"
module yuyv_to_rgb888_pair (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [yrgb_pkg::IN_W-1:0]   s_tdata,  // luma_first, chroma_u, luma_second, chroma_v
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [yrgb_pkg::OUT_W-1:0]  m_tdata   // blue_first, green_first, red_first,
	                                             // blue_second, green_second, red_second
);
	import yrgb_pkg::*;

	logic       valid_s1, valid_s2, valid_s3, valid_s4;
	logic       rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	yrgb_ctrl_t ctrl;

	assign rdy_s4 = !valid_s4 || m_tready;
	assign rdy_s3 = !valid_s3 || rdy_s4;
	assign rdy_s2 = !valid_s2 || rdy_s3;
	assign rdy_s1 = !valid_s1 || rdy_s2;

	assign ctrl.en_s1 = rdy_s1;
	assign ctrl.en_s2 = rdy_s2;
	assign ctrl.en_s3 = rdy_s3;
	assign ctrl.en_s4 = rdy_s4;

	assign s_tready = rdy_s1;
	assign m_tvalid = valid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy_s1) valid_s1 <= s_tvalid;
			if (rdy_s2) valid_s2 <= valid_s1;
			if (rdy_s3) valid_s3 <= valid_s2;
			if (rdy_s4) valid_s4 <= valid_s3;
		end
	end

	yrgb_datapath u_datapath (
		.clk      (clk),
		.ctrl     (ctrl),
		.in_word  (s_tdata),
		.out_word (m_tdata)
	);

	`YRGB_ASSERT_NOW(a_no_block_when_drained, m_tready, s_tready, "input blocked while output drains")
	`YRGB_ASSERT_NEXT(a_out_from_s3, !m_tvalid, !m_tvalid || $past(valid_s3), "output word without stage 3 word")
	`YRGB_ASSERT_NEXT(a_fill_rate, 1'b1, $countones({valid_s1, valid_s2, valid_s3, valid_s4}) <= $past($countones({valid_s1, valid_s2, valid_s3, valid_s4})) + 1, "pipeline gained more than one word")

endmodule

/* dv/tb_yuyv_to_rgb888_pair.sv */
`timescale 1ns / 1ps
// Self-checking testbench for yuyv_to_rgb888_pair: directed macro-pixels, then random traffic
// under three idle/stall mixes, all outputs checked vs typed pairs or a local fixed-point model.
// Depends on yrgb_pkg and the yuyv_to_rgb888_pair RTL.
module tb_yuyv_to_rgb888_pair;
	import yrgb_pkg::*;

	localparam int SHIFT    = 12;
	localparam int K_RED_U  = 5743;
	localparam int K_GRN_U  = 1409;
	localparam int K_GRN_V  = 2925;
	localparam int K_BLU_V  = 7258;
	localparam int MID      = 128;
	localparam int RAND_PER_PHASE = 300;
	localparam int SETTLE   = 8;

	typedef struct {
		logic [IN_W-1:0]  word;
		bit               typed;
		logic [OUT_W-1:0] pair;
	} dir_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_W-1:0]    m_tdata;

	int                  send_idle_pct = 9;
	int                  recv_stall_pct = 66;
	int                  words_sent = 0;
	int                  pairs_checked = 0;
	int                  fail_count = 0;
	logic [OUT_W-1:0]    pair_staged_q[$];
	logic [OUT_W-1:0]    pair_due_q[$];
	dir_row_t            dir_tab[$];
	string               chan_name[6] = '{"blue_first", "green_first", "red_first",
		"blue_second", "green_second", "red_second"};

	yuyv_to_rgb888_pair uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [IN_W-1:0] macro_pixel(input int y0, input int u, input int y1,
		input int v);
		return {v[7:0], y1[7:0], u[7:0], y0[7:0]};
	endfunction

	function automatic logic [OUT_W-1:0] bgr_pair(input int b0, input int g0, input int r0,
		input int b1, input int g1, input int r1);
		return {r1[7:0], g1[7:0], b1[7:0], r0[7:0], g0[7:0], b0[7:0]};
	endfunction

	// floor by arithmetic shift, then saturate
	function automatic int clamp_chan(input int acc);
		int v;
		v = acc >>> SHIFT;
		if (v < 0) begin
			return 0;
		end else if (v > 255) begin
			return 255;
		end
		return v;
	endfunction

	// red takes U and blue takes V (swapped roles)
	function automatic logic [OUT_W-1:0] yuyv_to_bgr_pair(input logic [IN_W-1:0] mp);
		int y0, y1, du, dv, b[2], g[2], r[2];
		y0 = int'(mp[7:0]);
		du = int'(mp[15:8]) - MID;
		y1 = int'(mp[23:16]);
		dv = int'(mp[31:24]) - MID;
		for (int p = 0; p < 2; p++) begin
			int base;
			base = (p == 0 ? y0 : y1) * 4096;
			b[p] = clamp_chan(base + K_BLU_V * dv);
			g[p] = clamp_chan(base - K_GRN_U * du - K_GRN_V * dv);
			r[p] = clamp_chan(base + K_RED_U * du);
		end
		return bgr_pair(b[0], g[0], r[0], b[1], g[1], r[1]);
	endfunction

	// leans towards the extremes and the chroma midpoint now and then
	function automatic int pick_byte();
		int corner[5] = '{0, 1, 127, 128, 255};
		if ($urandom_range(3) == 0) begin
			return corner[$urandom_range(4)];
		end
		return $urandom_range(255);
	endfunction

	task automatic send_word(input logic [IN_W-1:0] mp, input logic [OUT_W-1:0] want);
		pair_staged_q.push_back(want);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= mp;
		do @(posedge clk); while (!s_tready);
		words_sent++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pair_due_q.size() != 0 || pair_staged_q.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		logic [OUT_W-1:0] want;
		if (arst_n) begin
			if (s_tvalid && s_tready && pair_staged_q.size() != 0) begin
				pair_due_q.push_back(pair_staged_q.pop_front());
			end
			if (m_tvalid && m_tready) begin
				if (pair_due_q.size() == 0) begin
					$error("output word %h with nothing expected", m_tdata);
					fail_count++;
				end else begin
					want = pair_due_q.pop_front();
					pairs_checked++;
					for (int k = 0; k < 6; k++) begin
						if (m_tdata[8*k +: 8] !== want[8*k +: 8]) begin
							$error("%s: expected %0d, got %0d", chan_name[k],
								want[8*k +: 8], m_tdata[8*k +: 8]);
							fail_count++;
						end
					end
				end
			end
		end
	end

	initial begin
		logic [IN_W-1:0] mp;
		// grey: zero chroma, output equals luma
		dir_tab.push_back('{macro_pixel(0, MID, 0, MID), 1'b1, bgr_pair(0, 0, 0, 0, 0, 0)});
		dir_tab.push_back('{macro_pixel(255, MID, 255, MID), 1'b1,
			bgr_pair(255, 255, 255, 255, 255, 255)});
		dir_tab.push_back('{macro_pixel(0, MID, 255, MID), 1'b1,
			bgr_pair(0, 0, 0, 255, 255, 255)});
		dir_tab.push_back('{macro_pixel(1, MID, 254, MID), 1'b1,
			bgr_pair(1, 1, 1, 254, 254, 254)});
		dir_tab.push_back('{macro_pixel(128, MID, 127, MID), 1'b1,
			bgr_pair(128, 128, 128, 127, 127, 127)});
		// chroma and luma corners, saturation both ways
		dir_tab.push_back('{macro_pixel(0, 0, 0, 0), 1'b0, '0});
		dir_tab.push_back('{macro_pixel(255, 255, 255, 255), 1'b0, '0});
		dir_tab.push_back('{macro_pixel(0, 255, 255, 0), 1'b0, '0});
		dir_tab.push_back('{macro_pixel(255, 0, 0, 255), 1'b0, '0});
		dir_tab.push_back('{macro_pixel(255, 255, 0, 0), 1'b0, '0});
		dir_tab.push_back('{macro_pixel(0, 0, 255, 255), 1'b0, '0});
		dir_tab.push_back('{macro_pixel(8'h55, 8'hAA, 8'hAA, 8'h55), 1'b0, '0});
		dir_tab.push_back('{macro_pixel(8'hAA, 8'h55, 8'h55, 8'hAA), 1'b0, '0});
		// one step off the midpoint, then two mixed values: negative fractions must floor
		dir_tab.push_back('{macro_pixel(0, 127, 1, 127), 1'b0, '0});
		dir_tab.push_back('{macro_pixel(254, 129, 255, 129), 1'b0, '0});
		dir_tab.push_back('{macro_pixel(250, 200, 5, 60), 1'b0, '0});
		dir_tab.push_back('{macro_pixel(16, 90, 235, 240), 1'b0, '0});

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			send_word(dir_tab[i].word,
				dir_tab[i].typed ? dir_tab[i].pair : yuyv_to_bgr_pair(dir_tab[i].word));
		end
		wait_drained();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct  = (ph == 0) ? 9 : (ph == 1) ? 66 : 0;
			recv_stall_pct = (ph == 0) ? 66 : (ph == 1) ? 9 : 0;
			for (int n = 0; n < RAND_PER_PHASE; n++) begin
				mp = macro_pixel(pick_byte(), pick_byte(), pick_byte(), pick_byte());
				send_word(mp, yuyv_to_bgr_pair(mp));
			end
			wait_drained();
		end

		repeat (SETTLE) @(posedge clk);
		$display("%0d macro-pixels sent (%0d directed), %0d pixel pairs checked",
			words_sent, dir_tab.size(), pairs_checked);
		$display("idle mixes: sender-light/receiver-heavy, reversed, and back-to-back");
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout: %0d pairs still due", pair_due_q.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl
rtl/yrgb_pkg.sv
rtl/yrgb_datapath.sv
rtl/yuyv_to_rgb888_pair.sv
dv/tb_yuyv_to_rgb888_pair.sv
